// File: sv/hbp_pkg.sv
package hbp_pkg;

	// Input word kinds
	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_DATA = 2'd1,
		KIND_END  = 2'd2,
		KIND_RSVD = 2'd3
	} kind_t;

	// Fixed field widths of the channels
	localparam int KIND_W     = 2;
	localparam int ENTRY_LEN_W = 5;
	localparam int BYTE_W     = 8;
	// Bits that can be left over between bytes
	localparam int PEND_W     = 7;
	localparam int PEND_CNT_W = 3;

	// Control of the word held between table read and packer
	typedef struct packed {
		logic valid;
		logic is_end;
	} slot_ctl_t;

endpackage

// File: sv/hbp_table.sv
module hbp_table
	import hbp_pkg::*;
#(
	parameter int NUM_SYMBOLS   = 257,
	parameter int MAX_CODE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_fire,
	input  logic [KIND_W-1:0]                kind,
	input  logic [$clog2(NUM_SYMBOLS)-1:0]   symbol,
	input  logic [MAX_CODE_BITS-1:0]         entry_code,
	input  logic [ENTRY_LEN_W-1:0]           entry_length,
	input  logic                             take,
	output slot_ctl_t                        ctl_s1,
	output logic [MAX_CODE_BITS-1:0]         code_s1,
	output logic [$clog2(MAX_CODE_BITS+1)-1:0] len_s1
);

	localparam int SYM_W = $clog2(NUM_SYMBOLS);
	localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);
	localparam logic [SYM_W-1:0] END_ADDR = SYM_W'(NUM_SYMBOLS - 1);

	logic [MAX_CODE_BITS-1:0] code_mem [NUM_SYMBOLS];
	logic [LEN_W-1:0]         len_mem  [NUM_SYMBOLS];

	logic             is_load;
	logic             is_data;
	logic             is_end;
	logic [LEN_W-1:0] sat_len;
	logic [SYM_W-1:0] rd_addr;

	// Decode the incoming word
	always_comb begin
		is_load = (kind == KIND_LOAD) && (int'(symbol) < NUM_SYMBOLS);
		is_data = (kind == KIND_DATA) && (int'(symbol) < NUM_SYMBOLS - 1);
		is_end  = (kind == KIND_END);
		rd_addr = is_data ? symbol : END_ADDR;
		if (int'(entry_length) > MAX_CODE_BITS) begin
			sat_len = LEN_W'(MAX_CODE_BITS);
		end else begin
			sat_len = LEN_W'(entry_length);
		end
	end

	// Table memory: at most one write or one read per accepted word
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (is_load) begin
				code_mem[symbol] <= entry_code;
				len_mem[symbol]  <= sat_len;
			end else if (is_data || is_end) begin
				code_s1 <= code_mem[rd_addr];
				len_s1  <= len_mem[rd_addr];
			end
		end
	end

	// Slot control: holds a code word until the packer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (in_fire && (is_data || is_end)) begin
			ctl_s1.valid  <= 1'b1;
			ctl_s1.is_end <= is_end;
		end else if (take) begin
			ctl_s1.valid <= 1'b0;
		end
	end

endmodule

// File: sv/hbp_packer.sv
module hbp_packer
	import hbp_pkg::*;
#(
	parameter int MAX_CODE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  slot_ctl_t                          ctl_s1,
	input  logic [MAX_CODE_BITS-1:0]           code_s1,
	input  logic [$clog2(MAX_CODE_BITS+1)-1:0] len_s1,
	output logic                               take,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [BYTE_W-1:0]                  out_byte,
	output logic                               has_byte,
	output logic                               last
);

	localparam int LEN_W  = $clog2(MAX_CODE_BITS + 1);
	localparam int ACC_W  = PEND_W + MAX_CODE_BITS;
	localparam int TOT_W  = $clog2(PEND_W + MAX_CODE_BITS + 1);
	localparam int MAXN   = (PEND_W + MAX_CODE_BITS) / BYTE_W;
	localparam int RES_W  = $clog2(MAXN + 2);

	logic [PEND_W-1:0]     pend_q;
	logic [PEND_CNT_W-1:0] pend_cnt_q;

	logic [ACC_W-1:0] emit_acc_q;
	logic [RES_W-1:0] emit_left_q;
	logic             emit_end_q;
	logic             emit_part_q;

	logic [MAX_CODE_BITS-1:0] masked;
	logic [ACC_W-1:0]         acc;
	logic [ACC_W-1:0]         acc_rest;
	logic [TOT_W-1:0]         total;
	logic [RES_W-1:0]         results;
	logic                     emit_free;
	logic                     out_fire;

	// Append the code above the pending bits and count full bytes
	always_comb begin
		masked   = code_s1 & ~({MAX_CODE_BITS{1'b1}} << len_s1);
		acc      = ACC_W'(pend_q) | (ACC_W'(masked) << pend_cnt_q);
		total    = TOT_W'(pend_cnt_q) + TOT_W'(len_s1);
		acc_rest = acc >> {total[TOT_W-1:3], 3'b000};
		results  = RES_W'(total[TOT_W-1:3]) + RES_W'(ctl_s1.is_end);
	end

	// A word with no result passes at once; others wait for a free emitter
	always_comb begin
		out_fire  = out_valid && out_ready;
		emit_free = (emit_left_q == '0) || ((emit_left_q == RES_W'(1)) && out_ready);
		take      = ctl_s1.valid && ((results == '0) || emit_free);
	end

	// Leftover bits; end of stream empties them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			pend_cnt_q <= '0;
		end else if (take) begin
			if (ctl_s1.is_end) begin
				pend_q     <= '0;
				pend_cnt_q <= '0;
			end else begin
				pend_q     <= acc_rest[PEND_W-1:0];
				pend_cnt_q <= total[PEND_CNT_W-1:0];
			end
		end
	end

	// Output register: shifts out one byte per accepted result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_left_q <= '0;
			emit_end_q  <= 1'b0;
			emit_part_q <= 1'b0;
		end else if (take && (results != '0)) begin
			emit_left_q <= results;
			emit_end_q  <= ctl_s1.is_end;
			emit_part_q <= (total[2:0] != 3'd0);
		end else if (out_fire) begin
			emit_left_q <= emit_left_q - RES_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take && (results != '0)) begin
			emit_acc_q <= acc;
		end else if (out_fire) begin
			emit_acc_q <= emit_acc_q >> BYTE_W;
		end
	end

	// Bytes above the written bits are zero, so a bare marker reads zero
	always_comb begin
		out_valid = (emit_left_q != '0);
		out_byte  = emit_acc_q[BYTE_W-1:0];
		last      = emit_end_q && (emit_left_q == RES_W'(1));
		has_byte  = !last || emit_part_q;
	end

endmodule

// File: sv/huffman_bit_packer_top.sv
// Huffman code packer, LSB first.
// Input channel (in_valid/in_ready) carries one word per item: kind selects a
// table load (symbol, entry_code, entry_length), a data byte to encode, or end
// of stream. Output channel (out_valid/out_ready) carries one packed byte per
// word: out_byte, has_byte, last. End of stream gives the remaining full bytes,
// then the zero-padded partial byte with last set, or a bare marker
// (has_byte low) when no bits were left.
// An accepted word passes the registered table read, then the output register.
// Throughput: one input word per cycle while each word yields at most one
// byte and the receiver is ready; a word yielding several results holds the
// output register until each result is taken, so the output port sets the
// rate. Loads and words that complete no byte pass without using the output
// register.
// Reset clears the leftover bits and all pending results; the code table is
// not cleared and must be loaded before use. When the receiver stalls the
// output holds, one more word can wait at the table output, then in_ready drops.
module huffman_bit_packer_top
	import hbp_pkg::*;
#(
	parameter int NUM_SYMBOLS   = 257,
	parameter int MAX_CODE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [KIND_W-1:0]                kind,
	input  logic [$clog2(NUM_SYMBOLS)-1:0]   symbol,
	input  logic [MAX_CODE_BITS-1:0]         entry_code,
	input  logic [ENTRY_LEN_W-1:0]           entry_length,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [BYTE_W-1:0]                out_byte,
	output logic                             has_byte,
	output logic                             last
);

	localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);

	slot_ctl_t                ctl_s1;
	logic [MAX_CODE_BITS-1:0] code_s1;
	logic [LEN_W-1:0]         len_s1;
	logic                     take;
	logic                     in_fire;

	// Accept while the slot is empty or being drained
	always_comb begin
		in_ready = !ctl_s1.valid || take;
		in_fire  = in_valid && in_ready;
	end

	hbp_table #(
		.NUM_SYMBOLS   (NUM_SYMBOLS),
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_fire      (in_fire),
		.kind         (kind),
		.symbol       (symbol),
		.entry_code   (entry_code),
		.entry_length (entry_length),
		.take         (take),
		.ctl_s1       (ctl_s1),
		.code_s1      (code_s1),
		.len_s1       (len_s1)
	);

	hbp_packer #(
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.code_s1   (code_s1),
		.len_s1    (len_s1),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.last      (last)
	);

	// A bare marker is always the final, empty result of a stream
	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_byte) |-> (last && (out_byte == '0)))
		else $error("bare marker without last or with data");

	// A held slot word is never dropped
	a_slot_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s1.valid && !take) |=> ctl_s1.valid)
		else $error("slot word lost");

	// The packer only takes a word that is present
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ctl_s1.valid)
		else $error("take without slot word");

	// A stalled slot blocks new input
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s1.valid && !take) |-> !in_ready)
		else $error("input accepted over a stalled slot");

endmodule

// File: test/tb_huffman_bit_packer_top.sv
`timescale 1ns / 1ps

module tb_huffman_bit_packer_top;
	import hbp_pkg::*;

	localparam int NUM_SYM     = 257;
	localparam int MAX_BITS    = 16;
	localparam int SYM_W       = $clog2(NUM_SYM);
	localparam int END_SYM     = NUM_SYM - 1;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 16;
	localparam int RAND_WORDS  = 270;

	// One packed output word
	typedef struct packed {
		logic [BYTE_W-1:0] data_val;
		logic              has;
		logic              fin;
	} out_word_t;

	// Predicts the packed byte stream and checks the block against it
	class bit_pack_predictor;
		logic [MAX_BITS-1:0]    code_tab [NUM_SYM];
		logic [ENTRY_LEN_W-1:0] len_tab [NUM_SYM];
		logic [PEND_W-1:0]      carry_bits;
		int unsigned            carry_cnt;
		out_word_t              expected_bytes [$];
		int                     errors;

		function void push_word(logic [BYTE_W-1:0] d, logic h, logic f);
			out_word_t w;
			w.data_val = d;
			w.has      = h;
			w.fin      = f;
			expected_bytes.push_back(w);
		endfunction

		// Append one table code and emit every full byte
		function void append_code(int unsigned idx);
			logic [31:0] acc;
			int unsigned total;
			acc = 32'(carry_bits) |
				((32'(code_tab[idx]) & ((32'd1 << len_tab[idx]) - 32'd1)) << carry_cnt);
			total = carry_cnt + len_tab[idx];
			while (total >= BYTE_W) begin
				push_word(acc[7:0], 1'b1, 1'b0);
				acc = acc >> BYTE_W;
				total -= BYTE_W;
			end
			carry_bits = acc[PEND_W-1:0];
			carry_cnt  = total;
		endfunction

		// Accepted input word
		function void take_word(logic [KIND_W-1:0] k, logic [SYM_W-1:0] sym,
				logic [MAX_BITS-1:0] code, logic [ENTRY_LEN_W-1:0] len);
			case (kind_t'(k))
				KIND_LOAD: begin
					if (sym < NUM_SYM) begin
						code_tab[sym] = code;
						len_tab[sym]  = (len > MAX_BITS) ? ENTRY_LEN_W'(MAX_BITS) : len;
					end
				end
				KIND_DATA: begin
					if (sym < END_SYM)
						append_code(32'(sym));
				end
				KIND_END: begin
					append_code(END_SYM);
					if (carry_cnt != 0)
						push_word({1'b0, carry_bits}, 1'b1, 1'b1);
					else
						push_word('0, 1'b0, 1'b1);
					carry_bits = '0;
					carry_cnt  = 0;
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string what);
			$display("%0t ns: mismatch: %s", $time, what);
			errors++;
		endtask

		// Accepted output word against the oldest expectation
		task check_word(logic [BYTE_W-1:0] d, logic h, logic f);
			out_word_t want;
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected word byte=%02h has_byte=%0b last=%0b",
					d, h, f));
				return;
			end
			want = expected_bytes.pop_front();
			if (d !== want.data_val)
				report_mismatch($sformatf("out_byte %02h, expected %02h", d, want.data_val));
			if (h !== want.has)
				report_mismatch($sformatf("has_byte %0b, expected %0b", h, want.has));
			if (f !== want.fin)
				report_mismatch($sformatf("last %0b, expected %0b", f, want.fin));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [KIND_W-1:0]      kind = '0;
	logic [SYM_W-1:0]       symbol = '0;
	logic [MAX_BITS-1:0]    entry_code = '0;
	logic [ENTRY_LEN_W-1:0] entry_length = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [BYTE_W-1:0]      out_byte;
	logic                   has_byte;
	logic                   last;

	bit_pack_predictor sb = new;
	bit                calm = 1'b0;
	bit                loaded [NUM_SYM];
	int                loaded_list [$];
	int                stall_cycles = 0;

	huffman_bit_packer_top #(
		.NUM_SYMBOLS  (NUM_SYM),
		.MAX_CODE_BITS(MAX_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.symbol      (symbol),
		.entry_code  (entry_code),
		.entry_length(entry_length),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.has_byte    (has_byte),
		.last        (last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Receiver: random back-pressure, none while calm
	always @(posedge clk) begin
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
	end

	// Monitor: results first, then the word accepted at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_word(out_byte, has_byte, last);
			if (in_valid && in_ready)
				sb.take_word(kind, symbol, entry_code, entry_length);
		end
	end

	// Watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
				$display("** huffman_bit_packer_top: FAILED **");
				$finish;
			end
		end
	end

	// Drive one word; valid stays high into the next word when there is no gap
	task automatic send_word(kind_t k, logic [SYM_W-1:0] sym, logic [MAX_BITS-1:0] code,
			logic [ENTRY_LEN_W-1:0] len);
		if (!calm) begin
			while ($urandom_range(99) < 38) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid     <= 1'b1;
		kind         <= k;
		symbol       <= sym;
		entry_code   <= code;
		entry_length <= len;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic load_entry(logic [SYM_W-1:0] sym, logic [MAX_BITS-1:0] code,
			logic [ENTRY_LEN_W-1:0] len);
		send_word(KIND_LOAD, sym, code, len);
		if (sym < END_SYM && !loaded[sym]) begin
			loaded[sym] = 1'b1;
			loaded_list.push_back(int'(sym));
		end
	endtask

	// Hold the sender until every expected word has come out
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int                     counted;
		int                     r;
		bit                     drained_mid;
		logic [SYM_W-1:0]       sym;
		logic [ENTRY_LEN_W-1:0] len;

		counted     = 0;
		drained_mid = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: table extremes, masking, saturation, ignored words
		load_entry(SYM_W'(END_SYM), 16'h0005, 5'd3);
		load_entry(0, 16'hFFFF, 5'd16);
		load_entry(255, 16'hA5C3, 5'd31);
		load_entry(1, 16'hFFFE, 5'd1);
		load_entry(2, 16'h0001, 5'd0);
		load_entry(3, 16'h007F, 5'd7);
		load_entry(300, 16'h1234, 5'd5);
		load_entry(511, 16'h5A5A, 5'd31);
		send_word(KIND_DATA, 0, 16'h0000, 5'd0);
		send_word(KIND_DATA, 1, 16'hFFFF, 5'd31);
		send_word(KIND_DATA, 255, 16'h0000, 5'd0);
		send_word(KIND_DATA, SYM_W'(END_SYM), 16'h0000, 5'd0);
		send_word(KIND_DATA, 511, 16'h0000, 5'd0);
		send_word(KIND_RSVD, 0, 16'hFFFF, 5'd16);
		send_word(KIND_DATA, 2, 16'h0000, 5'd0);
		send_word(KIND_END, 0, 16'h0000, 5'd0);
		// empty accumulator and empty end code: bare marker
		load_entry(SYM_W'(END_SYM), 16'h00F0, 5'd0);
		send_word(KIND_END, 0, 16'h0000, 5'd0);
		// seven leftover bits plus a long end code: three results
		send_word(KIND_DATA, 3, 16'h0000, 5'd0);
		load_entry(SYM_W'(END_SYM), 16'hBEEF, 5'd16);
		send_word(KIND_END, 0, 16'h0000, 5'd0);
		// whole bytes only, then bare marker after the end code
		send_word(KIND_DATA, 0, 16'h0000, 5'd0);
		send_word(KIND_END, 0, 16'h0000, 5'd0);
		wait_for_results();

		// Random: mostly data words from loaded symbols, some reloads and ends
		while (counted < RAND_WORDS) begin
			calm = (counted >= 120 && counted < 180);
			if (counted >= 230 && !drained_mid) begin
				wait_for_results();
				drained_mid = 1'b1;
			end
			r = $urandom_range(99);
			if (r < 12) begin
				sym = ($urandom_range(9) == 0) ? SYM_W'($urandom_range(257, 511))
					: SYM_W'($urandom_range(0, 256));
				r = $urandom_range(99);
				len = (r < 8) ? ENTRY_LEN_W'($urandom_range(17, 31))
					: (r < 14) ? '0 : ENTRY_LEN_W'($urandom_range(1, 16));
				load_entry(sym, MAX_BITS'($urandom), len);
				if (sym < NUM_SYM)
					counted++;
			end else if (r < 18) begin
				send_word(KIND_END, SYM_W'($urandom), MAX_BITS'($urandom),
					ENTRY_LEN_W'($urandom));
				counted++;
			end else if (r < 22) begin
				// noise: reserved kind, or a data word outside the byte range
				if ($urandom_range(1) == 0)
					send_word(KIND_RSVD, SYM_W'($urandom), MAX_BITS'($urandom),
						ENTRY_LEN_W'($urandom));
				else
					send_word(KIND_DATA, SYM_W'($urandom_range(256, 511)),
						MAX_BITS'($urandom), ENTRY_LEN_W'($urandom));
			end else begin
				sym = SYM_W'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
				send_word(KIND_DATA, sym, MAX_BITS'($urandom), ENTRY_LEN_W'($urandom));
				counted++;
			end
		end
		calm = 1'b0;

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("** huffman_bit_packer_top: PASSED **");
		else
			$display("** huffman_bit_packer_top: FAILED **");
		$finish;
	end

endmodule
